FILE: rtl/bezier_curve_split_unit_defines.svh
// ----------------------------------------------------------------------------
// bezier curve split unit assertion macros
// shared property forms for the concurrent checks of the split unit
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_SPLIT_UNIT_DEFINES_SVH
`define BEZIER_CURVE_SPLIT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define BCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define BCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// shared constants, point codes and control types of the bezier split unit
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

    // default widths
    localparam int COORD_WIDTH_DEF = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    // pipeline shape: input stage plus a multiply and an add stage per level
    localparam int NUM_LVL = 3;
    localparam int NUM_STG = 2 * NUM_LVL + 1;

    // point slots carried along the pipeline
    localparam int PT_P0   = 0;
    localparam int PT_P1   = 1;
    localparam int PT_P2   = 2;
    localparam int PT_P3   = 3;
    localparam int PT_A    = 4;
    localparam int PT_B    = 5;
    localparam int PT_C    = 6;
    localparam int PT_D    = 7;
    localparam int PT_E    = 8;
    localparam int PT_M    = 9;
    localparam int NUM_PTS = 10;

    // output sequence
    localparam int MAX_OUT = 7;
    localparam int IDX_W   = 3;
    localparam logic [IDX_W-1:0] QUAD_LAST  = 3'd4;
    localparam logic [IDX_W-1:0] CUBIC_LAST = 3'd6;

    // curve order codes
    localparam logic FUNC_QUAD  = 1'b0;
    localparam logic FUNC_CUBIC = 1'b1;

    // control from the last pipeline stage into the serializer
    typedef struct packed {
        logic vld;
        logic cubic;
    } t_ser_ctl;

    // first source slot of each interpolation level (level 3 is the result row)
    function automatic int lvl_base(input int lvl);
        int base;
        case (lvl)
            0:       base = PT_P0;
            1:       base = PT_A;
            2:       base = PT_D;
            default: base = PT_M;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bcs_lerp.sv
// ----------------------------------------------------------------------------
// bcs_lerp
// one interpolation lane: a + round((b - a) * t), registered product,
// rounding, add and saturation in the following stage
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_lerp #(
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = bcs_pkg::T_FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  signed [COORD_WIDTH-1:0]  i_a,
    input  wire  signed [COORD_WIDTH-1:0]  i_b,
    input  wire         [T_FRAC_BITS:0]    i_t,
    output logic signed [COORD_WIDTH-1:0]  o_res
);

    localparam int CW = COORD_WIDTH;
    localparam int TF = T_FRAC_BITS;
    localparam int PW = CW + TF + 2;
    localparam int SW = CW + 2;

    localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (TF - 1));
    localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic signed [PW-1:0] w_d;
    logic signed [PW-1:0] w_t;
    logic signed [PW-1:0] r_prod;
    logic signed [CW-1:0] r_a;
    logic signed [PW-1:0] w_rnd;
    logic signed [SW-1:0] w_sh;
    logic signed [SW-1:0] w_sum;

    // difference and multiplier operands, sign extended
    always_comb begin
        w_d = PW'({{2{i_b[CW-1]}}, i_b}) - PW'({{2{i_a[CW-1]}}, i_a});
        w_d = {{(PW-CW-1){w_d[CW]}}, w_d[CW:0]};
        w_t = PW'({1'b0, i_t});
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_d * w_t;
            r_a    <= i_a;
        end
    end

    // round to nearest with ties up, add and saturate
    always_comb begin
        w_rnd = r_prod + HALF;
        w_sh  = w_rnd[PW-1:TF];
        w_sum = {{2{r_a[CW-1]}}, r_a} + w_sh;
        if (w_sum > MAXV) begin
            o_res = MAXV[CW-1:0];
        end else if (w_sum < MINV) begin
            o_res = MINV[CW-1:0];
        end else begin
            o_res = w_sum[CW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bcs_serializer.sv
// ----------------------------------------------------------------------------
// bcs_serializer
// holds one finished split and sends its points one per transaction
// ----------------------------------------------------------------------------
`default_nettype none
`include "bezier_curve_split_unit_defines.svh"

module bcs_serializer #(
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  bcs_pkg::t_ser_ctl             i_ctl,
    output logic                                o_rdy,
    input  wire  signed [COORD_WIDTH-1:0]       i_px [bcs_pkg::MAX_OUT],
    input  wire  signed [COORD_WIDTH-1:0]       i_py [bcs_pkg::MAX_OUT],
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // px, py
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // point_index
    output logic [bcs_pkg::IDX_W-1:0]           m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int OUT_DW = ((2 * CW + 7) / 8) * 8;
    localparam int NO     = bcs_pkg::MAX_OUT;

    logic                          r_busy;
    logic [bcs_pkg::IDX_W-1:0]     r_idx;
    logic [bcs_pkg::IDX_W-1:0]     r_last;
    logic signed [CW-1:0]          r_sx [NO];
    logic signed [CW-1:0]          r_sy [NO];
    logic                          w_take;
    logic                          w_fin;
    logic                          w_ld;

    // handshake bookkeeping
    assign w_take = r_busy && m_axis_tready;
    assign w_fin  = w_take && (r_idx == r_last);
    assign o_rdy  = !r_busy || w_fin;
    assign w_ld   = i_ctl.vld && o_rdy;

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_last <= '0;
        end else if (w_ld) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_last <= i_ctl.cubic ? bcs_pkg::CUBIC_LAST : bcs_pkg::QUAD_LAST;
        end else if (w_take) begin
            if (w_fin) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // point slots: load whole list, shift one down per transaction
    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            for (int i = 0; i < NO; i++) begin
                r_sx[i] <= i_px[i];
                r_sy[i] <= i_py[i];
            end
        end else if (w_take) begin
            for (int i = 0; i < NO - 1; i++) begin
                r_sx[i] <= r_sx[i+1];
                r_sy[i] <= r_sy[i+1];
            end
        end
    end

    // output channel
    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = OUT_DW'({r_sy[0], r_sx[0]});
    assign m_axis_tuser  = r_idx;
    assign m_axis_tlast  = (r_idx == r_last);

    // checks
    `BCS_ASSERT_NOW(a_last_index, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, (m_axis_tuser == bcs_pkg::QUAD_LAST) || (m_axis_tuser == bcs_pkg::CUBIC_LAST), "last point at bad index")
    `BCS_ASSERT_NEXT(a_index_step, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 1'b1), "point index did not advance")
    `BCS_ASSERT_NEXT(a_load_start, i_clk, i_rst_n, i_ctl.vld && o_rdy, m_axis_tvalid && (m_axis_tuser == '0), "new split does not start at point zero")
    `BCS_ASSERT_NEXT(a_drain_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast && !i_ctl.vld, !m_axis_tvalid, "serializer busy after last point")

endmodule

`default_nettype wire

FILE: rtl/bezier_curve_split_unit.sv
// ----------------------------------------------------------------------------
// bezier_curve_split_unit
// de casteljau split of a quadratic or cubic bezier curve at parameter t
// ----------------------------------------------------------------------------
// Input channel s_axis: one transaction carries the control points and t in
// tdata and the curve order in tuser (0 quadratic, 1 cubic). Output channel
// m_axis: one transaction per control point of the two halves, px and py in
// tdata, the point position in tuser, tlast on the final point. A quadratic
// gives 5 points, a cubic 7, the shared middle point given once.
// The first point passes the input register, loaded at the accepting edge,
// then three levels of multiply stage plus round/add stage, then the output
// register. Throughput: the pipeline takes an item every cycle unless a
// stall has filled every stage; the output register sends one point per
// cycle while m_axis_tready is high, so the output channel, which carries
// every point of both halves, sets the sustained rate.
// Reset clears all valid bits; pipeline contents are dropped.
// When the receiver stalls, the current point holds on m_axis, the pipeline
// keeps filling its empty stages and then stops, and s_axis_tready drops
// once every stage holds an item. No item is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module bezier_curve_split_unit #(
    parameter int COORD_WIDTH = bcs_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = bcs_pkg::T_FRAC_BITS_DEF
) (
    input  wire                                               i_clk,
    input  wire                                               i_rst_n,
    input  wire                                               s_axis_tvalid,
    output logic                                              s_axis_tready,
    // x0, y0, x1, y1, x2, y2, x3, y3, t
    input  wire  [((8*COORD_WIDTH+T_FRAC_BITS+1+7)/8)*8-1:0]  s_axis_tdata,
    // func
    input  wire                                               s_axis_tuser,
    output logic                                              m_axis_tvalid,
    input  wire                                               m_axis_tready,
    // px, py
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]                m_axis_tdata,
    // point_index
    output logic [bcs_pkg::IDX_W-1:0]                         m_axis_tuser,
    output logic                                              m_axis_tlast
);

    localparam int CW   = COORD_WIDTH;
    localparam int TF   = T_FRAC_BITS;
    localparam int TW   = TF + 1;
    localparam int NS   = bcs_pkg::NUM_STG;
    localparam int NL   = bcs_pkg::NUM_LVL;
    localparam int NP   = bcs_pkg::NUM_PTS;
    localparam int NO   = bcs_pkg::MAX_OUT;

    localparam logic [TW-1:0] T_ONE = TW'(64'd1 << TF);

    // per-stage valid bits and records (coordinate 0 is x, 1 is y)
    logic [NS-1:0]          r_vld;
    logic [NS:0]            w_rdy;
    logic [NS-1:0]          w_vin;
    logic signed [CW-1:0]   r_pt [NS][2][NP];
    logic signed [CW-1:0]   n_pt [NS][2][NP];
    logic [TW-1:0]          r_t  [NS];
    logic [TW-1:0]          n_t0;
    logic [TW-1:0]          w_tin;
    logic [NS-1:0]          r_func;

    logic signed [CW-1:0]   w_lerp [NL][NL][2];
    logic signed [CW-1:0]   w_lx [NO];
    logic signed [CW-1:0]   w_ly [NO];
    bcs_pkg::t_ser_ctl      w_ctl;
    logic                   w_ser_rdy;

    // ready chain: a stage loads when empty or when its content moves on
    always_comb begin
        w_rdy[NS] = w_ser_rdy;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_vin[0] = s_axis_tvalid;
        for (int k = 1; k < NS; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign s_axis_tready = w_rdy[0];

    // clamp t to one
    always_comb begin
        w_tin = s_axis_tdata[8*CW +: TW];
        if (w_tin > T_ONE) begin
            n_t0 = T_ONE;
        end else begin
            n_t0 = w_tin;
        end
    end

    // next records: unpack input, copy forward, insert lane results
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int p = 0; p < NP; p++) begin
                n_pt[0][c][p] = '0;
            end
            for (int p = 0; p < 4; p++) begin
                n_pt[0][c][p] = s_axis_tdata[(2*p + c)*CW +: CW];
            end
        end
        for (int k = 1; k < NS; k++) begin
            n_pt[k] = r_pt[k-1];
        end
        for (int l = 0; l < NL; l++) begin
            for (int j = 0; j < NL; j++) begin
                if (j < NL - l) begin
                    for (int c = 0; c < 2; c++) begin
                        n_pt[2*l+2][c][bcs_pkg::lvl_base(l+1) + j] = w_lerp[l][j][c];
                    end
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_pt[k] <= n_pt[k];
            end
        end
        if (w_rdy[0]) begin
            r_t[0]    <= n_t0;
            r_func[0] <= s_axis_tuser;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_rdy[k]) begin
                r_t[k]    <= r_t[k-1];
                r_func[k] <= r_func[k-1];
            end
        end
    end

    // interpolation lanes: level l, lane j mixes slots base+j and base+j+1
    for (genvar gl = 0; gl < NL; gl++) begin : g_lvl
        for (genvar gj = 0; gj < NL; gj++) begin : g_lane
            if (gj < NL - gl) begin : g_on
                for (genvar gc = 0; gc < 2; gc++) begin : g_coord
                    bcs_lerp #(
                        .COORD_WIDTH (COORD_WIDTH),
                        .T_FRAC_BITS (T_FRAC_BITS)
                    ) u_lerp (
                        .i_clk (i_clk),
                        .i_en  (w_rdy[2*gl+1]),
                        .i_a   (r_pt[2*gl][gc][bcs_pkg::lvl_base(gl) + gj]),
                        .i_b   (r_pt[2*gl][gc][bcs_pkg::lvl_base(gl) + gj + 1]),
                        .i_t   (r_t[2*gl]),
                        .o_res (w_lerp[gl][gj][gc])
                    );
                end
            end
        end
    end

    // output point list in sequence order
    always_comb begin
        w_lx[0] = r_pt[NS-1][0][bcs_pkg::PT_P0];
        w_ly[0] = r_pt[NS-1][1][bcs_pkg::PT_P0];
        w_lx[1] = r_pt[NS-1][0][bcs_pkg::PT_A];
        w_ly[1] = r_pt[NS-1][1][bcs_pkg::PT_A];
        w_lx[2] = r_pt[NS-1][0][bcs_pkg::PT_D];
        w_ly[2] = r_pt[NS-1][1][bcs_pkg::PT_D];
        if (r_func[NS-1] == bcs_pkg::FUNC_CUBIC) begin
            w_lx[3] = r_pt[NS-1][0][bcs_pkg::PT_M];
            w_ly[3] = r_pt[NS-1][1][bcs_pkg::PT_M];
            w_lx[4] = r_pt[NS-1][0][bcs_pkg::PT_E];
            w_ly[4] = r_pt[NS-1][1][bcs_pkg::PT_E];
            w_lx[5] = r_pt[NS-1][0][bcs_pkg::PT_C];
            w_ly[5] = r_pt[NS-1][1][bcs_pkg::PT_C];
            w_lx[6] = r_pt[NS-1][0][bcs_pkg::PT_P3];
            w_ly[6] = r_pt[NS-1][1][bcs_pkg::PT_P3];
        end else begin
            w_lx[3] = r_pt[NS-1][0][bcs_pkg::PT_B];
            w_ly[3] = r_pt[NS-1][1][bcs_pkg::PT_B];
            w_lx[4] = r_pt[NS-1][0][bcs_pkg::PT_P2];
            w_ly[4] = r_pt[NS-1][1][bcs_pkg::PT_P2];
            w_lx[5] = r_pt[NS-1][0][bcs_pkg::PT_P2];
            w_ly[5] = r_pt[NS-1][1][bcs_pkg::PT_P2];
            w_lx[6] = r_pt[NS-1][0][bcs_pkg::PT_P2];
            w_ly[6] = r_pt[NS-1][1][bcs_pkg::PT_P2];
        end
        w_ctl.vld   = r_vld[NS-1];
        w_ctl.cubic = (r_func[NS-1] == bcs_pkg::FUNC_CUBIC);
    end

    // output register and point sequencing
    bcs_serializer #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_rdy         (w_ser_rdy),
        .i_px          (w_lx),
        .i_py          (w_ly),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: sim/bezier_curve_split_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_curve_split_unit_tb
// self-checking bench for the de casteljau curve split unit: a queue of curve
// transactions feeds a bursty stream driver, a point predictor builds the
// expected control points of both halves for each accepted curve, and a
// monitor checks every output point in order against them while the
// receiver stalls on its own pattern
// ----------------------------------------------------------------------------

module bezier_curve_split_unit_tb;

    localparam int  CW          = 24;
    localparam int  TF          = 16;
    localparam int  CLK_HALF    = 10;
    localparam int  RST_CYCLES  = 11;
    localparam int  DRAIN_CYC   = 24;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  RAND_CURVES = 280;
    localparam int  MAX_REPORTS = 40;
    localparam logic [TF:0] T_ONE = 17'h10000;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic [6:0][CW-1:0]   t_point_row;

    typedef struct packed {
        logic             func;
        logic [TF:0]      t;
        logic [3:0][CW-1:0] cx;
        logic [3:0][CW-1:0] cy;
    } t_curve_item;

    typedef struct packed {
        t_coord                    px;
        t_coord                    py;
        logic [bcs_pkg::IDX_W-1:0] idx;
        logic                      last;
    } t_split_point;

    // dut ports
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [215:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [47:0]   m_axis_tdata;
    logic [bcs_pkg::IDX_W-1:0] m_axis_tuser;
    logic          m_axis_tlast;

    // bench state
    t_curve_item   pending_curves[$];
    t_split_point  expected_points[$];
    t_curve_item   drv_curve = '0;
    int            curves_total = 0;
    int            curves_sent = 0;
    int            curves_taken = 0;
    int            burst_left = 4;
    int            gap_left = 0;
    int            rx_mode = 0;
    int            rx_left = 0;
    int            err_cnt = 0;
    int            cycle_cnt = 0;

    bezier_curve_split_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // clamp to the signed coordinate range
    function automatic t_coord clamp_coord(input longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return t_coord'(hi);
        if (v < lo) return t_coord'(lo);
        return t_coord'(v);
    endfunction

    // a + round((b - a) * t / 2^TF), ties toward plus infinity
    function automatic t_coord lerp_q16(input t_coord a, input t_coord b, input logic [TF:0] tq);
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = diff * longint'({47'd0, tq}) + (longint'(1) <<< (TF - 1));
        return clamp_coord(longint'(a) + (prod >>> TF));
    endfunction

    // control points of both halves along one axis, in output order
    function automatic t_point_row split_axis(input logic [3:0][CW-1:0] p, input logic cubic,
                                              input logic [TF:0] tq);
        t_point_row row;
        t_coord     a, b, c, d, e, m;
        row = '0;
        a = lerp_q16(p[0], p[1], tq);
        b = lerp_q16(p[1], p[2], tq);
        if (!cubic) begin
            m = lerp_q16(a, b, tq);
            row[0] = p[0];
            row[1] = a;
            row[2] = m;
            row[3] = b;
            row[4] = p[2];
        end else begin
            c = lerp_q16(p[2], p[3], tq);
            d = lerp_q16(a, b, tq);
            e = lerp_q16(b, c, tq);
            m = lerp_q16(d, e, tq);
            row[0] = p[0];
            row[1] = a;
            row[2] = d;
            row[3] = m;
            row[4] = e;
            row[5] = c;
            row[6] = p[3];
        end
        return row;
    endfunction

    // queue the expected points of one accepted curve
    task automatic predict_split(input t_curve_item cv);
        logic         cubic;
        logic [TF:0]  tq;
        t_point_row   rx, ry;
        logic [bcs_pkg::IDX_W-1:0] last_idx;
        t_split_point pt;
        cubic    = (cv.func == bcs_pkg::FUNC_CUBIC);
        tq       = (cv.t > T_ONE) ? T_ONE : cv.t;
        rx       = split_axis(cv.cx, cubic, tq);
        ry       = split_axis(cv.cy, cubic, tq);
        last_idx = cubic ? bcs_pkg::CUBIC_LAST : bcs_pkg::QUAD_LAST;
        for (int k = 0; k <= int'(last_idx); k++) begin
            pt.px   = rx[k];
            pt.py   = ry[k];
            pt.idx  = bcs_pkg::IDX_W'(k);
            pt.last = (bcs_pkg::IDX_W'(k) == last_idx);
            expected_points.push_back(pt);
        end
    endtask

    task automatic add_curve(input logic func, input logic [TF:0] tq,
                             input t_coord x0, input t_coord y0, input t_coord x1,
                             input t_coord y1, input t_coord x2, input t_coord y2,
                             input t_coord x3, input t_coord y3);
        t_curve_item cv;
        cv.func  = func;
        cv.t     = tq;
        cv.cx[0] = x0; cv.cy[0] = y0;
        cv.cx[1] = x1; cv.cy[1] = y1;
        cv.cx[2] = x2; cv.cy[2] = y2;
        cv.cx[3] = x3; cv.cy[3] = y3;
        pending_curves.push_back(cv);
        curves_total++;
    endtask

    // full range most of the time, with the range ends and small values mixed in
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 7))
            0:       return t_coord'(24'h800000);
            1:       return t_coord'(24'h7fffff);
            2:       return t_coord'($urandom_range(0, 511)) - t_coord'(256);
            default: return t_coord'($urandom());
        endcase
    endfunction

    function automatic logic [TF:0] rand_split_t();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 17'd0;
                    1:       return 17'd1;
                    2:       return 17'd65535;
                    default: return T_ONE;
                endcase
            end
            1:       return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // stream driver: bursts of transactions separated by random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || curves_taken == curves_sent)) begin
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_curves.size() > 0) begin
                drv_curve     = pending_curves.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drv_curve.func;
                s_axis_tdata  <= {7'd0, drv_curve.t,
                                  drv_curve.cy[3], drv_curve.cx[3],
                                  drv_curve.cy[2], drv_curve.cx[2],
                                  drv_curve.cy[1], drv_curve.cx[1],
                                  drv_curve.cy[0], drv_curve.cx[0]};
                curves_sent <= curves_sent + 1;
                if (burst_left <= 1) begin
                    burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                              : $urandom_range(1, 10);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready pattern: free running, random, or mostly stalled stretches
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 2);
                rx_left <= $urandom_range(10, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // input transactions feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_split(drv_curve);
            curves_taken <= curves_taken + 1;
        end
    end

    // output transactions checked against the oldest expected point
    always @(posedge i_clk) begin
        t_split_point got;
        t_split_point want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.px   = m_axis_tdata[23:0];
            got.py   = m_axis_tdata[47:24];
            got.idx  = m_axis_tuser;
            got.last = m_axis_tlast;
            if (expected_points.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected point px=%0d py=%0d idx=%0d last=%0b",
                             $time, got.px, got.py, got.idx, got.last);
            end else begin
                want = expected_points.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"%0t: point mismatch expected px=%0d py=%0d idx=%0d last=%0b",
                                  " actual px=%0d py=%0d idx=%0d last=%0b"},
                                 $time, want.px, want.py, want.idx, want.last,
                                 got.px, got.py, got.idx, got.last);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("bezier_curve_split_unit verification failed");
            $finish;
        end
    end

    initial begin
        // quadratic and cubic at both ends of t and beyond one
        add_curve(bcs_pkg::FUNC_QUAD,  17'd0,     100, -200, 3000, 4000, -5000, 600, 7, 8);
        add_curve(bcs_pkg::FUNC_QUAD,  T_ONE,     100, -200, 3000, 4000, -5000, 600, 7, 8);
        add_curve(bcs_pkg::FUNC_QUAD,  17'h1ffff, 100, -200, 3000, 4000, -5000, 600, 7, 8);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd0,     -900, 50, 1200, -3300, 4400, 5500, -6600, 7700);
        add_curve(bcs_pkg::FUNC_CUBIC, T_ONE,     -900, 50, 1200, -3300, 4400, 5500, -6600, 7700);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd65537, -900, 50, 1200, -3300, 4400, 5500, -6600, 7700);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd1,     -900, 50, 1200, -3300, 4400, 5500, -6600, 7700);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd65535, -900, 50, 1200, -3300, 4400, 5500, -6600, 7700);
        // rounding ties, upward and downward steps
        add_curve(bcs_pkg::FUNC_QUAD,  17'd32768, 0, 1, 1, 0, 2, 1, 0, 0);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd32768, 1, 0, 0, 1, 1, 0, 0, 1);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd16384, -1, 3, 2, -2, -3, 1, 1, -1);
        // coordinate range extremes
        add_curve(bcs_pkg::FUNC_QUAD,  17'd32768, 24'h800000, 24'h7fffff, 24'h7fffff,
                  24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd32768, 24'h800000, 24'h7fffff, 24'h7fffff,
                  24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd43690, 24'h7fffff, 24'h7fffff, 24'h7fffff,
                  24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd21845, 24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
        add_curve(bcs_pkg::FUNC_QUAD,  17'd65535, 24'h7fffff, 24'h800000, 24'h800000,
                  24'h7fffff, 24'h7fffff, 24'h800000, 24'h555555, 24'haaaaaa);
        add_curve(bcs_pkg::FUNC_CUBIC, 17'd1,     24'h800000, 24'h7fffff, 24'h7fffff,
                  24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);

        // random curves
        repeat (RAND_CURVES) begin
            add_curve($urandom_range(0, 1) ? bcs_pkg::FUNC_CUBIC : bcs_pkg::FUNC_QUAD,
                      rand_split_t(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end

        // reset
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for all curves taken and all points seen, then drain
        while (curves_taken != curves_total || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("bezier_curve_split_unit verification clean");
        end else begin
            $display("bezier_curve_split_unit verification failed");
        end
        $finish;
    end

endmodule
